// File: rtl/core/sscg_pkg.sv
package sscg_pkg;

    // Command codes carried in the operation field
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_SET   = 2'd3
    } op_t;

    // What the last stage does with the held value
    typedef enum logic [1:0] {
        KIND_HOLD = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_SINE = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_VALUE  = 2'd0;
    localparam logic [1:0] CFG_MAX_VALUE  = 2'd1;
    localparam logic [1:0] CFG_PHASE_STEP = 2'd2;

    localparam logic signed [31:0] MIN_VALUE_RESET = 32'sd0;
    localparam logic signed [31:0] MAX_VALUE_RESET = 32'sd65536;

    // Sine magnitude in unsigned Q0.15
    localparam int          MAG_BITS = 15;
    localparam logic [14:0] MAG_MAX  = 15'd32767;
    localparam logic [15:0] MAG_MID  = 16'd32768;

    // pi/2 in unsigned Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor divisors (2n)(2n+1) for n = 1..6
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // One command as it moves down the pipeline
    typedef struct packed {
        kind_t       kind;
        logic        running;
        logic        rejected;
        logic [31:0] manual;
    } item_t;

    // Quadrant handling for the quarter-wave lookup
    typedef struct packed {
        logic neg;
        logic force_max;
    } sine_sel_t;

    // Quarter-wave entry k of a 2^bits table, evaluated at elaboration only
    function automatic logic [14:0] sine_rom_entry(input int unsigned k,
                                                   input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(k)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[n - 1];
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32767)
            sum = 64'sd32767;
        return sum[14:0];
    endfunction

endpackage

// File: rtl/core/sscg_cmd.sv
module sscg_cmd
    import sscg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [1:0]                 operation,
    input  logic [31:0]                manual_value,
    input  logic [31:0]                phase_step,
    output item_t                      item,
    output logic [SINE_TABLE_BITS-1:0] addr,
    output sine_sel_t                  sel
);

    localparam int IDX_LSB = PHASE_BITS - SINE_TABLE_BITS - 2;

    logic                       running_reg;
    logic                       running_next;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    item_t                      item_reg;
    item_t                      item_next;
    logic [SINE_TABLE_BITS-1:0] addr_reg;
    logic [SINE_TABLE_BITS-1:0] addr_next;
    sine_sel_t                  sel_reg;
    sine_sel_t                  sel_next;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;

    // Quadrant and table index from the phase before this tick
    assign idx  = phase_reg[IDX_LSB +: SINE_TABLE_BITS];
    assign quad = phase_reg[PHASE_BITS-1 -: 2];

    always_comb
    begin
        addr_next          = quad[0] ? (-idx) : idx;
        sel_next.neg       = quad[1];
        sel_next.force_max = quad[0] && (idx == '0);
    end

    // Command decode
    always_comb
    begin
        running_next       = running_reg;
        phase_next         = phase_reg;
        item_next.kind     = KIND_HOLD;
        item_next.rejected = 1'b0;
        item_next.manual   = manual_value;
        case (op_t'(operation))
            OP_TICK:
            begin
                if (running_reg)
                begin
                    item_next.kind = KIND_SINE;
                    phase_next     = phase_reg + PHASE_BITS'(phase_step);
                end
            end
            OP_START:
            begin
                running_next = 1'b1;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
            end
            OP_SET:
            begin
                if (running_reg)
                    item_next.rejected = 1'b1;
                else
                    item_next.kind = KIND_LOAD;
            end
            default:
            begin
                item_next.kind = KIND_HOLD;
            end
        endcase
        item_next.running = running_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            phase_reg   <= '0;
        end
        else if (accept)
        begin
            running_reg <= running_next;
            phase_reg   <= phase_next;
        end
    end

    // Stage one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
            addr_reg <= addr_next;
            sel_reg  <= sel_next;
        end
    end

    assign item = item_reg;
    assign addr = addr_reg;
    assign sel  = sel_reg;

endmodule

// File: rtl/core/sscg_sine_rom.sv
module sscg_sine_rom
    import sscg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic                       clk,
    input  logic                       load,
    input  logic [SINE_TABLE_BITS-1:0] addr,
    input  sine_sel_t                  sel_in,
    input  item_t                      item_in,
    output logic [MAG_BITS-1:0]        mag,
    output sine_sel_t                  sel_out,
    output item_t                      item_out
);

    localparam int ROM_DEPTH = 1 << SINE_TABLE_BITS;

    logic [MAG_BITS-1:0] rom_table [ROM_DEPTH];
    logic [MAG_BITS-1:0] mag_reg;
    sine_sel_t           sel_reg;
    item_t               item_reg;

    // Quarter-wave contents, fixed at elaboration
    for (genvar k = 0; k < ROM_DEPTH; k++)
    begin : g_rom
        assign rom_table[k] = sine_rom_entry(k, SINE_TABLE_BITS);
    end

    // Registered read, request details travel alongside
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg  <= rom_table[addr];
            sel_reg  <= sel_in;
            item_reg <= item_in;
        end
    end

    assign mag      = mag_reg;
    assign sel_out  = sel_reg;
    assign item_out = item_reg;

endmodule

// File: rtl/core/sscg_scale.sv
module sscg_scale
    import sscg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_mul,
    input  logic                load_out,
    input  logic [MAG_BITS-1:0] mag,
    input  sine_sel_t           sel,
    input  item_t               item_in,
    input  logic signed [31:0]  min_value,
    input  logic signed [31:0]  max_value,
    output logic [31:0]         current_value,
    output logic                is_running,
    output logic                rejected
);

    logic [MAG_BITS-1:0] mag_eff;
    logic [15:0]         weight;
    logic signed [32:0]  diff;
    logic signed [49:0]  prod_next;
    logic signed [49:0]  prod_reg;
    item_t               item_reg;
    logic signed [50:0]  rounded;
    logic signed [34:0]  frac;
    logic signed [34:0]  sum;
    logic [31:0]         held_next;
    logic [31:0]         held_reg;
    logic                run_reg;
    logic                rej_reg;

    // 32768 + s, always in 1..65535
    always_comb
    begin
        mag_eff = sel.force_max ? MAG_MAX : mag;
        weight  = sel.neg ? (MAG_MID - 16'(mag_eff)) : (MAG_MID + 16'(mag_eff));
    end

    // Span times weight, both operands widened to the full product
    assign diff      = 33'(max_value) - 33'(min_value);
    assign prod_next = 50'(diff) * 50'($signed({1'b0, weight}));

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg <= prod_next;
            item_reg <= item_in;
        end
    end

    // Round half up, floor by 2^16, add lower bound
    always_comb
    begin
        rounded = 51'(prod_reg) + 51'sd32768;
        frac    = rounded[50:16];
        sum     = 35'(min_value) + frac;
        case (item_reg.kind)
            KIND_SINE: held_next = sum[31:0];
            KIND_LOAD: held_next = item_reg.manual;
            KIND_HOLD: held_next = held_reg;
            default:   held_next = held_reg;
        endcase
    end

    // Output register doubles as the held value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            run_reg  <= 1'b0;
            rej_reg  <= 1'b0;
        end
        else if (load_out)
        begin
            held_reg <= held_next;
            run_reg  <= item_reg.running;
            rej_reg  <= item_reg.rejected;
        end
    end

    assign current_value = held_reg;
    assign is_running    = run_reg;
    assign rejected      = rej_reg;

endmodule

// File: rtl/core/scaled_sine_coefficient_generator.sv
// Channel   Direction  Handshake              Payload
// cmd       in         cmd_valid / cmd_stall  operation, manual_value
// res       out        res_valid / res_stall  current_value, is_running, rejected
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command per cycle sustained while res_stall is low; a result is offered
// once its request has passed four registers: decode, sine ROM registered read,
// multiplier register, output register.
// Reset (rst_n, asynchronous) stops generation, clears phase and held value,
// and loads the bound and step registers with their defaults.
// A stalled result holds; empty stages close up so requests keep flowing.
module scaled_sine_coefficient_generator
    import sscg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] manual_value,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] current_value,
    output logic        is_running,
    output logic        rejected,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [31:0]         min_reg;
    logic signed [31:0]         max_reg;
    logic [31:0]                step_reg;
    logic                       v1_reg;
    logic                       v1_next;
    logic                       v2_reg;
    logic                       v2_next;
    logic                       v3_reg;
    logic                       v3_next;
    logic                       v4_reg;
    logic                       v4_next;
    logic                       rdy1;
    logic                       rdy2;
    logic                       rdy3;
    logic                       rdy4;
    logic                       accept;
    logic                       ld2;
    logic                       ld3;
    logic                       ld4;
    item_t                      item1;
    item_t                      item2;
    logic [SINE_TABLE_BITS-1:0] addr1;
    sine_sel_t                  sel1;
    sine_sel_t                  sel2;
    logic [MAG_BITS-1:0]        mag2;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= MIN_VALUE_RESET;
            max_reg  <= MAX_VALUE_RESET;
            step_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_VALUE:  min_reg  <= cfg_data;
                CFG_MAX_VALUE:  max_reg  <= cfg_data;
                CFG_PHASE_STEP: step_reg <= cfg_data;
                default:        step_reg <= step_reg;
            endcase
        end
    end

    // Stage ready chain, a stage takes new data when empty or moving on
    always_comb
    begin
        rdy4    = !v4_reg || !res_stall;
        rdy3    = !v3_reg || rdy4;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        accept  = cmd_valid && rdy1;
        ld2     = v1_reg && rdy2;
        ld3     = v2_reg && rdy3;
        ld4     = v3_reg && rdy4;
        v1_next = accept || (v1_reg && !rdy2);
        v2_next = ld2 || (v2_reg && !rdy3);
        v3_next = ld3 || (v3_reg && !rdy4);
        v4_next = ld4 || (v4_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign cmd_stall = !rdy1;
    assign res_valid = v4_reg;

    // Decode, run flag and phase accumulator
    sscg_cmd #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_cmd (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .manual_value (manual_value),
        .phase_step   (step_reg),
        .item         (item1),
        .addr         (addr1),
        .sel          (sel1)
    );

    // Quarter-wave lookup
    sscg_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk      (clk),
        .load     (ld2),
        .addr     (addr1),
        .sel_in   (sel1),
        .item_in  (item1),
        .mag      (mag2),
        .sel_out  (sel2),
        .item_out (item2)
    );

    // Scaling, offset and held value
    sscg_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_mul      (ld3),
        .load_out      (ld4),
        .mag           (mag2),
        .sel           (sel2),
        .item_in       (item2),
        .min_value     (min_reg),
        .max_value     (max_reg),
        .current_value (current_value),
        .is_running    (is_running),
        .rejected      (rejected)
    );

endmodule

// File: rtl/core/sscg_checker.sv
module sscg_assert
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [31:0] current_value,
    input logic        is_running,
    input logic        rejected
);

    logic       take_cmd;
    logic       take_res;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    assign take_cmd = cmd_valid && !cmd_stall;
    assign take_res = res_valid && !res_stall;

    // Requests taken whose results are not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (take_cmd && !take_res)
            pending_next = pending_reg + 3'd1;
        else if (!take_cmd && take_res)
            pending_next = pending_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result stays
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(current_value) && $stable(is_running)
            && $stable(rejected))
        else $error("stalled result changed");

    // Never a result without a request behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 3'd0)
        else $error("result with no request outstanding");

    // Four stages hold at most four requests
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more requests in flight than stages");

    // A refused manual set only happens while running
    a_reject_running: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && rejected |-> is_running)
        else $error("rejection reported while stopped");

endmodule

bind scaled_sine_coefficient_generator sscg_assert u_sscg_assert (.*);
